// File: rtl/ranked_weighted_random_select_macros.svh
// Assertion macros for the ranked weighted random select block.
// Depends on nothing; included by the top level only.
`ifndef RANKED_WEIGHTED_RANDOM_SELECT_MACROS_SVH
`define RANKED_WEIGHTED_RANDOM_SELECT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define RWRS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RWRS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/rwrs_pkg.sv
// Shared constants and types for the ranked weighted random select block.
// No dependencies; imported by every module of the block.
package rwrs_pkg;

   localparam int MAX_CANDIDATES_DEF = 8;

   localparam int RANK_W      = 8;
   localparam int WEIGHT_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int KEPT_W      = 15;   // kept weights are positive, below 2^15
   localparam int FLOOR_W     = 9;
   localparam int THR_W       = 15;
   localparam int CHOSEN_W    = 3;

   localparam logic signed [FLOOR_W-1:0] RANK_FLOOR_RST = -9'sd1;
   localparam logic [THR_W-1:0]          THR_RST        = 15'd26;  // ~0.1 in Q8.8

   // register indexes of the csr port
   localparam logic CSR_RANK_FLOOR       = 1'b0;
   localparam logic CSR_WEIGHT_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [RANK_W-1:0]   rank;
      logic [WEIGHT_W-1:0] weight;
   } cand_type;

   typedef struct packed {
      logic we;
      logic shift;
   } load_ctl_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } sort_ctl_type;

endpackage

// File: rtl/rwrs_load_cell.sv
// One slot of the load chain: holds a candidate word in load order.
// Depends on rwrs_pkg; shifts toward the head during the replay pass.
module rwrs_load_cell
   import rwrs_pkg::*;
(
   input  logic         clock,
   input  load_ctl_type ctl,
   input  cand_type     load_data,
   input  cand_type     right_data,
   output cand_type     data
);

   cand_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.we) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: rtl/rwrs_sort_cell.sv
// One slot of the sorted chain: parallel insertion by ascending weight,
// stable for equal weights, then shift toward the head for the walk.
// Depends on rwrs_pkg.
module rwrs_sort_cell
   import rwrs_pkg::*;
#(
   parameter int IDX_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  sort_ctl_type      ctl,
   input  logic [KEPT_W-1:0] new_w,
   input  logic [IDX_W-1:0]  new_idx,
   input  logic              left_valid,
   input  logic [KEPT_W-1:0] left_w,
   input  logic [IDX_W-1:0]  left_idx,
   input  logic              right_valid,
   input  logic [KEPT_W-1:0] right_w,
   input  logic [IDX_W-1:0]  right_idx,
   output logic              valid,
   output logic [KEPT_W-1:0] w,
   output logic [IDX_W-1:0]  idx
);

   logic              valid_ff, valid_in;
   logic [KEPT_W-1:0] w_ff, w_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              from_left, take_new;

   // left neighbor heavier: it moves one slot down the chain into us
   assign from_left = left_valid && (left_w > new_w);
   // equal weights stay ahead of the new word
   assign take_new  = left_valid && !from_left && (!valid_ff || (w_ff > new_w));

   always_comb begin
      valid_in = valid_ff;
      w_in     = w_ff;
      idx_in   = idx_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         if (from_left) begin
            valid_in = 1'b1;
            w_in     = left_w;
            idx_in   = left_idx;
         end else if (take_new) begin
            valid_in = 1'b1;
            w_in     = new_w;
            idx_in   = new_idx;
         end
      end else if (ctl.shift) begin
         valid_in = right_valid;
         w_in     = right_w;
         idx_in   = right_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      idx_ff <= idx_in;
   end

   assign valid = valid_ff;
   assign w     = w_ff;
   assign idx   = idx_ff;

endmodule

// File: rtl/ranked_weighted_random_select.sv
// Top level of the ranked weighted random select block (roulette selection).
// Depends on rwrs_pkg, rwrs_load_cell, rwrs_sort_cell and the macros header.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata rank,weight,frac; tlast last
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata chosen_index; tuser none
//  csr     | in  | csr_we (always taken)  | csr_index, csr_wdata
//
// Words load one per cycle into the load chain while req_tready is high. The
// word with tlast closes a decision of n stored words: the load chain replays
// them into the sorted chain (ST_INSERT), random * total is formed (ST_MUL),
// the sorted chain is walked (ST_WALK, skipped when nothing is kept) and the
// result is staged (ST_DONE). req_tready is low over that span, longer while
// the output register still holds an unaccepted word.
// Reset is synchronous, active high.
`include "ranked_weighted_random_select_macros.svh"

module ranked_weighted_random_select
   import rwrs_pkg::*;
#(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] cand_rank, [23:8] cand_weight,
                                    // [39:24] random_frac
   input  logic        req_tlast,   // last_cand
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] chosen_index, [7:3] zero
   output logic        rsp_tuser,   // [0] none_chosen
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_CANDIDATES);
   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
   localparam int TOT_W = KEPT_W + $clog2(MAX_CANDIDATES);
   localparam int TGT_W = FRAC_W + TOT_W;
   localparam int XW    = (IDX_W > CHOSEN_W) ? IDX_W : CHOSEN_W;

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // ---------------- registers ----------------
   logic [2:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;     // words loaded so far
   logic [CNT_W-1:0]            n_ff, n_in;             // words in this decision
   logic [CNT_W-1:0]            p_ff, p_in;             // replay position
   logic signed [FLOOR_W-1:0]   floor_ff;
   logic [THR_W-1:0]            thr_ff;
   logic signed [FLOOR_W-1:0]   top_ff, top_in;         // running top rank
   logic [FRAC_W-1:0]           frac_ff, frac_in;
   logic [TOT_W-1:0]            total_ff, total_in;
   logic                        any_kept_ff, any_kept_in;
   logic [TGT_W-1:0]            target_ff, target_in;
   logic [TOT_W-1:0]            cum_ff, cum_in;
   logic [CHOSEN_W-1:0]         res_idx_ff, res_idx_in;
   logic                        res_none_ff, res_none_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CHOSEN_W-1:0]         rsp_idx_ff, rsp_idx_in;
   logic                        rsp_none_ff, rsp_none_in;

   // ---------------- request decode ----------------
   logic [RANK_W-1:0]           cand_rank;
   logic signed [WEIGHT_W-1:0]  cand_weight;
   logic [FRAC_W-1:0]           random_frac;
   logic                        acc, store, raise;
   logic signed [FLOOR_W-1:0]   top_base, rank_s;

   assign cand_rank   = req_tdata[7:0];
   assign cand_weight = req_tdata[23:8];
   assign random_frac = req_tdata[39:24];

   assign req_tready = (state_ff == ST_LOAD);
   assign acc        = req_tvalid && req_tready;
   assign store      = (count_ff < CNT_W'(MAX_CANDIDATES));
   assign rank_s     = $signed({1'b0, cand_rank});
   // a new decision starts its top rank from the floor register
   assign top_base   = (count_ff == '0) ? floor_ff : top_ff;
   assign raise      = store && (cand_weight > 16'sd0) && (rank_s > top_base);

   // ---------------- load chain ----------------
   cand_type     load_q [MAX_CANDIDATES];
   cand_type     load_word;
   cand_type     head;

   assign load_word.rank   = cand_rank;
   assign load_word.weight = cand_weight;
   assign head             = load_q[0];

   for (genvar k = 0; k < MAX_CANDIDATES; k++) begin : g_load
      load_ctl_type lctl;
      cand_type     right;
      assign lctl.we    = acc && store && (count_ff == CNT_W'(k));
      assign lctl.shift = (state_ff == ST_INSERT);
      if (k == MAX_CANDIDATES - 1) begin : g_tail
         assign right = '0;
      end else begin : g_mid
         assign right = load_q[k+1];
      end
      rwrs_load_cell u_cell (
         .clock      (clock),
         .ctl        (lctl),
         .load_data  (load_word),
         .right_data (right),
         .data       (load_q[k])
      );
   end

   // ---------------- filter on the replayed head ----------------
   logic                     keep;
   logic signed [16:0]       head_w17, thr17;

   assign head_w17 = $signed({head.weight[WEIGHT_W-1], head.weight});
   assign thr17    = $signed({2'b00, thr_ff});
   assign keep     = ($signed({1'b0, head.rank}) == top_ff) && (head_w17 > thr17);

   // ---------------- sorted chain ----------------
   sort_ctl_type             sctl;
   logic [MAX_CANDIDATES-1:0] sort_valid_vec;
   logic [KEPT_W-1:0]        sort_w   [MAX_CANDIDATES];
   logic [IDX_W-1:0]         sort_idx [MAX_CANDIDATES];
   logic [KEPT_W-1:0]        ins_w;
   logic [IDX_W-1:0]         ins_idx;
   logic [TOT_W-1:0]         cum_sum;
   logic                     hit;
   logic [XW-1:0]            head_idx_ext;

   assign ins_w   = head.weight[KEPT_W-1:0];
   assign ins_idx = p_ff[IDX_W-1:0];

   // roulette step: cumulative weight at the head against random * total
   assign cum_sum      = cum_ff + TOT_W'(sort_w[0]);
   assign hit          = (target_ff < {cum_sum, 16'b0});
   assign head_idx_ext = XW'(sort_idx[0]);

   always_comb begin
      sctl.clear  = acc && req_tlast;
      sctl.insert = (state_ff == ST_INSERT) && keep;
      sctl.shift  = (state_ff == ST_WALK) && !hit;
   end

   for (genvar k = 0; k < MAX_CANDIDATES; k++) begin : g_sort
      logic              lv, rv;
      logic [KEPT_W-1:0] lw, rw;
      logic [IDX_W-1:0]  li, ri;
      if (k == 0) begin : g_head
         // always open on the left: a new word may settle in the head slot
         assign lv = 1'b1;
         assign lw = '0;
         assign li = '0;
      end else begin : g_left
         assign lv = sort_valid_vec[k-1];
         assign lw = sort_w[k-1];
         assign li = sort_idx[k-1];
      end
      if (k == MAX_CANDIDATES - 1) begin : g_tail
         assign rv = 1'b0;
         assign rw = '0;
         assign ri = '0;
      end else begin : g_right
         assign rv = sort_valid_vec[k+1];
         assign rw = sort_w[k+1];
         assign ri = sort_idx[k+1];
      end
      rwrs_sort_cell #(.IDX_W(IDX_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (sctl),
         .new_w       (ins_w),
         .new_idx     (ins_idx),
         .left_valid  (lv),
         .left_w      (lw),
         .left_idx    (li),
         .right_valid (rv),
         .right_w     (rw),
         .right_idx   (ri),
         .valid       (sort_valid_vec[k]),
         .w           (sort_w[k]),
         .idx         (sort_idx[k])
      );
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      p_in        = p_ff;
      top_in      = top_ff;
      frac_in     = frac_ff;
      total_in    = total_ff;
      any_kept_in = any_kept_ff;
      target_in   = target_ff;
      cum_in      = cum_ff;
      res_idx_in  = res_idx_ff;
      res_none_in = res_none_ff;
      case (state_ff)
         ST_LOAD: begin
            if (acc) begin
               top_in = raise ? rank_s : top_base;
               if (store) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  n_in        = store ? (count_ff + CNT_W'(1)) : count_ff;
                  count_in    = '0;
                  p_in        = '0;
                  frac_in     = random_frac;
                  total_in    = '0;
                  any_kept_in = 1'b0;
                  state_in    = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            if (keep) begin
               total_in    = total_ff + TOT_W'(ins_w);
               any_kept_in = 1'b1;
            end
            p_in = p_ff + CNT_W'(1);
            if ((p_ff + CNT_W'(1)) == n_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            target_in = TGT_W'(frac_ff) * TGT_W'(total_ff);
            cum_in    = '0;
            if (any_kept_ff) begin
               state_in = ST_WALK;
            end else begin
               res_idx_in  = '0;
               res_none_in = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_WALK: begin
            // the last kept word always hits, since random < 1
            cum_in = cum_sum;
            if (hit) begin
               res_idx_in  = head_idx_ext[CHOSEN_W-1:0];
               res_none_in = 1'b0;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_none_in  = rsp_none_ff;
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = res_idx_ff;
         rsp_none_in  = res_none_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         floor_ff     <= RANK_FLOOR_RST;
         thr_ff       <= THR_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_RANK_FLOOR:       floor_ff <= $signed(csr_wdata[FLOOR_W-1:0]);
               CSR_WEIGHT_THRESHOLD: thr_ff   <= csr_wdata[THR_W-1:0];
               default:              thr_ff   <= thr_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      p_ff        <= p_in;
      top_ff      <= top_in;
      frac_ff     <= frac_in;
      total_ff    <= total_in;
      any_kept_ff <= any_kept_in;
      target_ff   <= target_in;
      cum_ff      <= cum_in;
      res_idx_ff  <= res_idx_in;
      res_none_ff <= res_none_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_idx_ff};
   assign rsp_tuser  = rsp_none_ff;

   // ---------------- assertions ----------------
   `RWRS_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= CNT_W'(MAX_CANDIDATES), "load count beyond chain length")
   `RWRS_ASSERT_IMPLIES(a_walk_head_valid, clock, reset,
      state_ff == ST_WALK, sort_valid_vec[0], "roulette walk ran off the sorted chain")
   `RWRS_ASSERT_ALWAYS(a_sort_packed, clock, reset,
      (sort_valid_vec & (sort_valid_vec + MAX_CANDIDATES'(1))) == '0,
      "sorted chain has a gap")

endmodule
